/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions; clk and rst come from the
// module that uses them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/hpdpa_pkg.sv */
// ----------------------------------------------------------------------------
// HPD pulse to attention package
// Widths, codes, records and helpers shared by the front, link FIFO and
// back of the converter.
// ----------------------------------------------------------------------------
package hpdpa_pkg;

  localparam int TS_W       = 48;
  localparam int DEG_W      = 16;
  localparam int SPC_W      = 20;
  localparam int POS_W      = 3;
  localparam int LEFT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int DEF_QUEUE_SLOTS = 4;
  localparam int LINK_DEPTH      = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEGLITCH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IRQ_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MF_PREF  = 3'd4;

  // Register reset values
  localparam logic [DEG_W-1:0] RST_DEGLITCH = 16'd250;
  localparam logic [DEG_W-1:0] RST_IRQ_MAX  = 16'd2000;
  localparam logic [SPC_W-1:0] RST_SPACING  = 20'd10000;
  localparam logic [POS_W-1:0] RST_POSITION = 3'd0;
  localparam logic             RST_MF_PREF  = 1'b0;

  typedef enum logic [2:0] {
    PH_LOW_WAIT   = 3'd0,
    PH_HIGH_CHECK = 3'd1,
    PH_HIGH_WAIT  = 3'd2,
    PH_LOW_CHECK  = 3'd3,
    PH_IRQ_CHECK  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    EV_LOW  = 2'd0,
    EV_HIGH = 2'd1,
    EV_IRQ  = 2'd2
  } ev_t;

  // One classified item handed from front to back
  typedef struct packed {
    logic            ev_valid;
    ev_t             ev;
    logic [TS_W-1:0] timestamp;
    logic            permit_send;
    logic            restart;
  } link_t;

  typedef struct packed {
    logic [DEG_W-1:0] deglitch_us;
    logic [DEG_W-1:0] irq_max_us;
  } front_cfg_t;

  typedef struct packed {
    logic [SPC_W-1:0] spacing_us;
    logic [POS_W-1:0] position;
    logic             mf_pref;
  } back_cfg_t;

  // Add with saturation at the top of the timestamp range
  function automatic logic [TS_W-1:0] sat_add(input logic [TS_W-1:0] t,
                                              input logic [TS_W-1:0] d);
    logic [TS_W:0] s;
    s = {1'b0, t} + {1'b0, d};
    return s[TS_W] ? {TS_W{1'b1}} : s[TS_W-1:0];
  endfunction

endpackage

/* src/hpdpa_front.sv */
// ----------------------------------------------------------------------------
// HPD deglitch front
// Runs the five-phase deglitch machine on each accepted sample and hands
// the classified item (event, timestamp, control bits) to the link FIFO.
// ----------------------------------------------------------------------------
module hpdpa_front (
  input  logic                     clk,
  input  logic                     rst,
  input  hpdpa_pkg::front_cfg_t    cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     level,
  input  logic [hpdpa_pkg::TS_W-1:0] timestamp,
  input  logic                     permit_send,
  input  logic                     restart,
  output logic                     link_valid,
  input  logic                     link_ready,
  output hpdpa_pkg::link_t         link
);
  import hpdpa_pkg::*;

  phase_t          phase, phase_next, phase_cur;
  logic [TS_W-1:0] deadline, deadline_next, dl_cur;
  logic [TS_W-1:0] irq_extra, win_end, dl_deg, dl_irq;
  logic            ev_valid;
  ev_t             ev;
  logic            take;

  assign take       = in_valid && link_ready;
  assign in_ready   = link_ready;
  assign link_valid = in_valid;

  // Restart puts the machine back to low wait before this sample
  assign phase_cur = restart ? PH_LOW_WAIT : phase;
  assign dl_cur    = restart ? '0 : deadline;

  // Extra IRQ window beyond the deglitch time, zero when not wider
  assign irq_extra = (cfg.irq_max_us > cfg.deglitch_us) ?
                     TS_W'(cfg.irq_max_us - cfg.deglitch_us) : '0;
  assign win_end   = sat_add(dl_cur, irq_extra);
  assign dl_deg    = sat_add(timestamp, TS_W'(cfg.deglitch_us));
  assign dl_irq    = sat_add(timestamp, irq_extra);

  // Next phase and deadline
  always_comb begin
    phase_next    = phase_cur;
    deadline_next = dl_cur;
    case (phase_cur)
      PH_HIGH_CHECK: begin
        if (!level || timestamp <= dl_cur) phase_next = PH_LOW_WAIT;
        else phase_next = PH_HIGH_WAIT;
      end
      PH_HIGH_WAIT: begin
        if (!level) begin
          phase_next    = PH_LOW_CHECK;
          deadline_next = dl_deg;
        end
      end
      PH_LOW_CHECK: begin
        if (!level) begin
          phase_next    = PH_IRQ_CHECK;
          deadline_next = dl_irq;
        end else begin
          phase_next = PH_HIGH_WAIT;
        end
      end
      PH_IRQ_CHECK: begin
        if (level) phase_next = PH_HIGH_WAIT;
        else if (timestamp > dl_cur) phase_next = PH_LOW_WAIT;
      end
      default: begin
        phase_next = PH_LOW_WAIT;
        if (level) begin
          phase_next    = PH_HIGH_CHECK;
          deadline_next = dl_deg;
        end
      end
    endcase
  end

  // Classify the sample into an event
  always_comb begin
    ev_valid = 1'b0;
    ev       = EV_LOW;
    case (phase_cur)
      PH_HIGH_CHECK: begin
        if (level && timestamp > dl_cur) begin
          ev_valid = 1'b1;
          ev       = EV_HIGH;
        end
      end
      PH_LOW_CHECK: begin
        if (level && timestamp >= dl_cur && timestamp <= win_end) begin
          ev_valid = 1'b1;
          ev       = EV_IRQ;
        end
      end
      PH_IRQ_CHECK: begin
        if (level && timestamp <= dl_cur) begin
          ev_valid = 1'b1;
          ev       = EV_IRQ;
        end else if (!level && timestamp > dl_cur) begin
          ev_valid = 1'b1;
          ev       = EV_LOW;
        end
      end
      default: begin
        ev_valid = 1'b0;
      end
    endcase
  end

  // Build the item for the back
  always_comb begin
    link.ev_valid    = ev_valid;
    link.ev          = ev;
    link.timestamp   = timestamp;
    link.permit_send = permit_send;
    link.restart     = restart;
  end

  // Advance machine state on each accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LOW_WAIT;
      deadline <= '0;
    end else if (take) begin
      phase    <= phase_next;
      deadline <= deadline_next;
    end
  end

endmodule

/* src/hpdpa_fifo.sv */
// ----------------------------------------------------------------------------
// HPD link FIFO
// Short queue of classified items between the front and the back, so
// each side can stall on its own.
// ----------------------------------------------------------------------------
module hpdpa_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  hpdpa_pkg::link_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output hpdpa_pkg::link_t pop_data
);
  import hpdpa_pkg::*;

  localparam int PTR_W = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
  localparam int CNT_W = $clog2(LINK_DEPTH + 1);

  link_t              mem [LINK_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push, pop;

  assign push_ready = (count != CNT_W'(LINK_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Store the incoming item
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(LINK_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(LINK_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* src/hpdpa_back.sv */
// ----------------------------------------------------------------------------
// HPD attention back
// Applies restart and send permission, keeps the event queue with its
// drop rules, decides the send and holds the attention result until taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpdpa_back #(
  parameter int QUEUE_SLOTS = hpdpa_pkg::DEF_QUEUE_SLOTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  hpdpa_pkg::back_cfg_t         cfg,
  input  logic                         rec_valid,
  output logic                         rec_ready,
  input  hpdpa_pkg::link_t             rec,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         irq_hpd,
  output logic                         hpd_asserted,
  output logic [hpdpa_pkg::POS_W-1:0]  position,
  output logic                         mf_pref,
  output logic [hpdpa_pkg::LEFT_W-1:0] still_queued
);
  import hpdpa_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_SLOTS + 1);
  localparam int IDX_W = $clog2(QUEUE_SLOTS);

  ev_t              queue [QUEUE_SLOTS];
  ev_t              q_w   [QUEUE_SLOTS];
  ev_t              q_next[QUEUE_SLOTS];
  logic [CNT_W-1:0] count, cnt_w, count_next;
  logic             send_allowed, allowed_w;
  logic [TS_W-1:0]  last_sent, last_w, last_next, elapsed;
  logic [IDX_W-1:0] wr_idx, chk_idx;
  logic             full, irq_block, do_push, send, take;
  ev_t              head;

  assign take      = rec_valid && rec_ready;
  assign rec_ready = !out_valid || out_ready;

  // Apply restart, permit and the event push
  always_comb begin
    cnt_w     = count;
    allowed_w = send_allowed;
    last_w    = last_sent;
    for (int i = 0; i < QUEUE_SLOTS; i++) q_w[i] = queue[i];
    if (rec.restart) begin
      cnt_w     = '0;
      allowed_w = 1'b0;
      last_w    = '0;
    end
    if (rec.permit_send) allowed_w = 1'b1;
    if (rec.ev_valid && rec.ev == EV_LOW) cnt_w = '0;
    full      = (cnt_w == CNT_W'(QUEUE_SLOTS));
    wr_idx    = cnt_w[IDX_W-1:0];
    chk_idx   = IDX_W'(cnt_w - CNT_W'(2));
    irq_block = (rec.ev == EV_IRQ) && (cnt_w >= CNT_W'(2)) && (queue[chk_idx] == EV_IRQ);
    do_push   = rec.ev_valid && !full && !irq_block;
    if (do_push) begin
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
        if (wr_idx == IDX_W'(i)) q_w[i] = rec.ev;
      end
      cnt_w = cnt_w + 1'b1;
    end
  end

  // Decide the send and pop the oldest event
  assign elapsed = rec.timestamp - last_w;
  assign send    = (cnt_w != '0) && allowed_w && (cfg.position != '0) &&
                   (elapsed > TS_W'(cfg.spacing_us));
  assign head    = q_w[0];

  always_comb begin
    for (int i = 0; i < QUEUE_SLOTS; i++) q_next[i] = q_w[i];
    count_next = cnt_w;
    last_next  = last_w;
    if (send) begin
      for (int i = 0; i < QUEUE_SLOTS - 1; i++) q_next[i] = q_w[i + 1];
      count_next = cnt_w - 1'b1;
      last_next  = rec.timestamp;
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < QUEUE_SLOTS; i++) queue[i] <= q_next[i];
    end
  end

  // Queue control and send timing
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      send_allowed <= 1'b0;
      last_sent    <= '0;
    end else if (take) begin
      count        <= count_next;
      send_allowed <= allowed_w;
      last_sent    <= last_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= send;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && send) begin
      irq_hpd      <= (head == EV_IRQ);
      hpd_asserted <= (head != EV_LOW);
      position     <= cfg.position;
      mf_pref      <= cfg.mf_pref;
      still_queued <= (count_next > CNT_W'(3)) ? LEFT_W'(3) : count_next[LEFT_W-1:0];
    end
  end

  `ASSERT_CHK(a_count_range, count <= CNT_W'(QUEUE_SLOTS), "event count beyond queue size")
  `ASSERT_CHK(a_pos_nonzero, out_valid |-> position != '0, "result sent with position zero")
  `ASSERT_CHK(a_send_stamp, (take && send) |=> last_sent == $past(rec.timestamp), "send time not kept")
  `ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> (count == '0 && !out_valid), "queue not empty after reset")

endmodule

/* src/hpd_pulse_to_attention_converter.sv */
// Path: an accepted sample is stored in the link FIFO; the back registers its result.
// Throughput: one sample per cycle while the link FIFO has room; the front machine,
// the two-entry link FIFO and the back queue each update once per accepted item,
// and a held result stalls only the back until the FIFO fills.
// Reset: synchronous, clears machine, queue count, send timing and permission,
// and loads the register defaults; the event slots need no clearing.
// ----------------------------------------------------------------------------
// HPD pulse to attention converter
// Top level: configuration registers, deglitch front, link FIFO and
// attention back.
// ----------------------------------------------------------------------------
module hpd_pulse_to_attention_converter #(
  parameter int QUEUE_SLOTS = hpdpa_pkg::DEF_QUEUE_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hpdpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpdpa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             level,
  input  logic [hpdpa_pkg::TS_W-1:0]       timestamp,
  input  logic                             permit_send,
  input  logic                             restart,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             irq_hpd,
  output logic                             hpd_asserted,
  output logic [hpdpa_pkg::POS_W-1:0]      position,
  output logic                             mf_pref,
  output logic [hpdpa_pkg::LEFT_W-1:0]     still_queued
);
  import hpdpa_pkg::*;

  logic [DEG_W-1:0] deglitch_us, irq_max_us;
  logic [SPC_W-1:0] spacing_us;
  logic [POS_W-1:0] object_position;
  logic             multifunction_pref;
  front_cfg_t       front_cfg;
  back_cfg_t        back_cfg;
  logic             link_valid, link_ready, rec_valid, rec_ready;
  link_t            link, rec;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      deglitch_us        <= RST_DEGLITCH;
      irq_max_us         <= RST_IRQ_MAX;
      spacing_us         <= RST_SPACING;
      object_position    <= RST_POSITION;
      multifunction_pref <= RST_MF_PREF;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEGLITCH: deglitch_us        <= cfg_data[DEG_W-1:0];
        REG_IRQ_MAX:  irq_max_us         <= cfg_data[DEG_W-1:0];
        REG_SPACING:  spacing_us         <= cfg_data[SPC_W-1:0];
        REG_POSITION: object_position    <= cfg_data[POS_W-1:0];
        REG_MF_PREF:  multifunction_pref <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    front_cfg.deglitch_us = deglitch_us;
    front_cfg.irq_max_us  = irq_max_us;
    back_cfg.spacing_us   = spacing_us;
    back_cfg.position     = object_position;
    back_cfg.mf_pref      = multifunction_pref;
  end

  hpdpa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (front_cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .level      (level),
    .timestamp  (timestamp),
    .permit_send(permit_send),
    .restart    (restart),
    .link_valid (link_valid),
    .link_ready (link_ready),
    .link       (link)
  );

  hpdpa_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(link_valid),
    .push_ready(link_ready),
    .push_data (link),
    .pop_valid (rec_valid),
    .pop_ready (rec_ready),
    .pop_data  (rec)
  );

  hpdpa_back #(
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (back_cfg),
    .rec_valid   (rec_valid),
    .rec_ready   (rec_ready),
    .rec         (rec),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .irq_hpd     (irq_hpd),
    .hpd_asserted(hpd_asserted),
    .position    (position),
    .mf_pref     (mf_pref),
    .still_queued(still_queued)
  );

endmodule
